@@ hdl/alu_with_condition_flags_defines.svh @@
// Assertion helpers for the ALU RTL.
`ifndef ALU_WITH_CONDITION_FLAGS_DEFINES_SVH
`define ALU_WITH_CONDITION_FLAGS_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ALU_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ALU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/alu_cf_pkg.sv @@
package alu_cf_pkg;

   typedef logic [63:0] data_type;
   typedef logic [3:0]  kind_type;
   typedef logic [1:0]  width_code_type;
   typedef logic [2:0]  cond_type;
   typedef logic [1:0]  error_type;
   typedef logic [3:0]  flags_type;

   localparam kind_type KIND_ADD  = 4'd0;
   localparam kind_type KIND_SUB  = 4'd1;
   localparam kind_type KIND_MUL  = 4'd2;
   localparam kind_type KIND_DIV  = 4'd3;
   localparam kind_type KIND_AND  = 4'd4;
   localparam kind_type KIND_OR   = 4'd5;
   localparam kind_type KIND_XOR  = 4'd6;
   localparam kind_type KIND_SHL  = 4'd7;
   localparam kind_type KIND_SHR  = 4'd8;
   localparam kind_type KIND_NOT  = 4'd9;
   localparam kind_type KIND_CMP  = 4'd10;
   localparam kind_type KIND_TEST = 4'd11;
   localparam kind_type KIND_COND = 4'd12;

   localparam width_code_type WIDTH_8  = 2'd0;
   localparam width_code_type WIDTH_16 = 2'd1;
   localparam width_code_type WIDTH_32 = 2'd2;
   localparam width_code_type WIDTH_64 = 2'd3;

   localparam cond_type COND_EQ = 3'd0;
   localparam cond_type COND_NE = 3'd1;
   localparam cond_type COND_LO = 3'd2;
   localparam cond_type COND_HS = 3'd3;
   localparam cond_type COND_LT = 3'd4;
   localparam cond_type COND_GE = 3'd5;

   localparam error_type ERR_NONE  = 2'd0;
   localparam error_type ERR_DIV0  = 2'd1;
   localparam error_type ERR_SHIFT = 2'd2;

   // flag bit positions
   localparam int FLAG_Z = 0;
   localparam int FLAG_S = 1;
   localparam int FLAG_C = 2;
   localparam int FLAG_V = 3;

   // one quotient or multiplier bit per step
   localparam logic [5:0] ITER_LAST = 6'd63;

   function automatic data_type mask_of(input width_code_type wc);
      data_type m;
      unique case (wc)
         WIDTH_8:  m = 64'h0000_0000_0000_00FF;
         WIDTH_16: m = 64'h0000_0000_0000_FFFF;
         WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
         default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic [6:0] width_bits(input width_code_type wc);
      logic [6:0] w;
      unique case (wc)
         WIDTH_8:  w = 7'd8;
         WIDTH_16: w = 7'd16;
         WIDTH_32: w = 7'd32;
         default:  w = 7'd64;
      endcase
      return w;
   endfunction

   // top bit of the selected width
   function automatic logic sign_of(input data_type v, input width_code_type wc);
      logic s;
      unique case (wc)
         WIDTH_8:  s = v[7];
         WIDTH_16: s = v[15];
         WIDTH_32: s = v[31];
         default:  s = v[63];
      endcase
      return s;
   endfunction

   // bit just above the selected width
   function automatic logic carry_of(input logic [64:0] v, input width_code_type wc);
      logic c;
      unique case (wc)
         WIDTH_8:  c = v[8];
         WIDTH_16: c = v[16];
         WIDTH_32: c = v[32];
         default:  c = v[64];
      endcase
      return c;
   endfunction

   function automatic logic cond_holds(input cond_type cc, input flags_type f);
      logic h;
      unique case (cc)
         COND_EQ: h = f[FLAG_Z];
         COND_NE: h = !f[FLAG_Z];
         COND_LO: h = f[FLAG_C];
         COND_HS: h = !f[FLAG_C];
         COND_LT: h = f[FLAG_S] ^ f[FLAG_V];
         COND_GE: h = !(f[FLAG_S] ^ f[FLAG_V]);
         default: h = 1'b0;
      endcase
      return h;
   endfunction

endpackage

@@ hdl/alu_with_condition_flags.sv @@
// Single-step operations go from IDLE to FINISH; multiply and nonzero divide
// run 64 loop steps in LOOP first. FINISH waits for a free output register and
// loads it, raising rsp_valid. A new request is taken only in IDLE, so one is in
// flight at a time (a zero divisor takes the short path); the shared 66-bit adder
// is stepped one bit per cycle in LOOP. Reset (synchronous, active high) clears the
// flags, idles the sequencer and drops rsp_valid.
`include "alu_with_condition_flags_defines.svh"

module alu_with_condition_flags (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  alu_cf_pkg::kind_type        req_kind,
   input  alu_cf_pkg::width_code_type  req_width_code,
   input  alu_cf_pkg::data_type        req_left_operand,
   input  alu_cf_pkg::data_type        req_right_operand,
   input  alu_cf_pkg::cond_type        req_condition_code,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output alu_cf_pkg::data_type        rsp_result_value,
   output logic                        rsp_zero_flag,
   output logic                        rsp_sign_flag,
   output logic                        rsp_carry_flag,
   output logic                        rsp_overflow_flag,
   output logic                        rsp_condition_true,
   output alu_cf_pkg::error_type       rsp_error_code
);
   import alu_cf_pkg::*;

   // Sequencer: IDLE takes a request, LOOP steps multiply/divide, FINISH
   // evaluates and hands the result to the output register.
   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_LOOP   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type      state_ff, state_in;
   kind_type       kind_ff, kind_in;
   width_code_type wc_ff, wc_in;
   cond_type       cc_ff, cc_in;
   data_type       op_a_ff, op_a_in;
   data_type       op_b_ff, op_b_in;
   data_type       acc_hi_ff, acc_hi_in;   // product high half / partial remainder
   data_type       acc_lo_ff, acc_lo_in;   // product low half / quotient
   logic [5:0]     cnt_ff, cnt_in;
   flags_type      flags_ff, flags_in;

   logic           rsp_valid_ff, rsp_valid_in;
   data_type       rsp_result_ff, rsp_result_in;
   flags_type      rsp_flags_ff, rsp_flags_in;
   logic           rsp_cond_ff, rsp_cond_in;
   error_type      rsp_err_ff, rsp_err_in;

   // shared adder
   logic [65:0]    add_x, add_y, add_sum;
   logic           add_sub;

   // finish-stage evaluation
   data_type       mask, req_mask;
   data_type       res_value;
   flags_type      res_flags;
   logic           res_cond;
   error_type      res_err;
   logic [64:0]    shl_full, shr_full;
   data_type       tmp;
   logic           load_rsp;

   assign req_mask = mask_of(req_width_code);
   assign mask     = mask_of(wc_ff);
   assign req_ready = (state_ff == S_IDLE);
   assign load_rsp  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Steer the one adder: multiply adds the multiplicand when the low bit
   // is set, divide trials a subtract of the divisor, everything else adds
   // or subtracts the two operands.
   always_comb begin
      add_x   = {2'b00, op_a_ff};
      add_y   = {2'b00, op_b_ff};
      add_sub = (kind_ff != KIND_ADD);
      if (state_ff == S_LOOP) begin
         if (kind_ff == KIND_MUL) begin
            add_x   = {2'b00, acc_hi_ff};
            add_y   = acc_lo_ff[0] ? {2'b00, op_a_ff} : 66'd0;
            add_sub = 1'b0;
         end else begin
            add_x   = {1'b0, acc_hi_ff, acc_lo_ff[63]};
            add_y   = {2'b00, op_b_ff};
            add_sub = 1'b1;
         end
      end
      add_sum = add_x + (add_sub ? ~add_y : add_y) + {65'd0, add_sub};
   end

   // Evaluate the held request once the operands (or the loop) are ready.
   always_comb begin
      res_value = '0;
      res_flags = flags_ff;
      res_cond  = 1'b0;
      res_err   = ERR_NONE;
      tmp       = '0;
      shl_full  = {1'b0, op_a_ff} << op_b_ff[5:0];
      shr_full  = {op_a_ff, 1'b0} >> op_b_ff[5:0];
      unique case (kind_ff)
         KIND_ADD: begin
            res_value = add_sum[63:0] & mask;
            tmp       = ~(op_a_ff ^ op_b_ff) & (op_a_ff ^ res_value);
            res_flags[FLAG_C] = carry_of(add_sum[64:0], wc_ff);
            res_flags[FLAG_V] = sign_of(tmp, wc_ff);
         end
         KIND_SUB, KIND_CMP: begin
            tmp = add_sum[63:0] & mask;
            if (kind_ff == KIND_SUB) begin
               res_value = tmp;
            end
            res_flags[FLAG_C] = add_sum[65];
            res_flags[FLAG_V] = sign_of((op_a_ff ^ op_b_ff) & (op_a_ff ^ tmp), wc_ff);
         end
         KIND_MUL: begin
            res_value = acc_lo_ff & mask;
            res_flags[FLAG_C] = (acc_hi_ff != '0) || ((acc_lo_ff & ~mask) != '0);
            res_flags[FLAG_V] = res_flags[FLAG_C];
         end
         KIND_DIV: begin
            if (op_b_ff == '0) begin
               res_err = ERR_DIV0;
            end else begin
               res_value = acc_lo_ff & mask;
            end
         end
         KIND_AND: res_value = op_a_ff & op_b_ff;
         KIND_OR:  res_value = op_a_ff | op_b_ff;
         KIND_XOR: res_value = op_a_ff ^ op_b_ff;
         KIND_SHL, KIND_SHR: begin
            if (op_b_ff >= {57'd0, width_bits(wc_ff)}) begin
               res_err = ERR_SHIFT;
            end else if (kind_ff == KIND_SHL) begin
               res_value = shl_full[63:0] & mask;
               res_flags[FLAG_C] = carry_of(shl_full, wc_ff);
            end else begin
               res_value = shr_full[64:1];
               res_flags[FLAG_C] = shr_full[0];
            end
         end
         KIND_NOT: res_value = ~op_a_ff & mask;
         KIND_TEST: tmp = op_a_ff & op_b_ff;
         KIND_COND: res_cond = cond_holds(cc_ff, flags_ff);
         default: ;
      endcase

      // Zero and sign come from the masked result (test uses left AND right);
      // carry and overflow clear unless set above. Errors, condition and
      // unused kinds keep the stored flags.
      if (res_err == ERR_NONE && kind_ff <= KIND_TEST) begin
         if (kind_ff != KIND_TEST && kind_ff != KIND_CMP) begin
            tmp = res_value;
         end
         res_flags[FLAG_Z] = (tmp == '0);
         res_flags[FLAG_S] = sign_of(tmp, wc_ff);
         if (kind_ff != KIND_ADD && kind_ff != KIND_SUB && kind_ff != KIND_CMP &&
             kind_ff != KIND_MUL && kind_ff != KIND_SHL && kind_ff != KIND_SHR) begin
            res_flags[FLAG_C] = 1'b0;
            res_flags[FLAG_V] = 1'b0;
         end else if (kind_ff == KIND_SHL || kind_ff == KIND_SHR) begin
            res_flags[FLAG_V] = 1'b0;
         end
      end
   end

   // Sequencer and datapath registers.
   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      wc_in     = wc_ff;
      cc_in     = cc_ff;
      op_a_in   = op_a_ff;
      op_b_in   = op_b_ff;
      acc_hi_in = acc_hi_ff;
      acc_lo_in = acc_lo_ff;
      cnt_in    = cnt_ff;
      flags_in  = flags_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // Latch the request with both operands masked to the width.
               kind_in   = req_kind;
               wc_in     = req_width_code;
               cc_in     = req_condition_code;
               op_a_in   = req_left_operand & req_mask;
               op_b_in   = req_right_operand & req_mask;
               acc_hi_in = '0;
               cnt_in    = '0;
               if (req_kind == KIND_MUL) begin
                  acc_lo_in = req_right_operand & req_mask;
                  state_in  = S_LOOP;
               end else if (req_kind == KIND_DIV &&
                            (req_right_operand & req_mask) != '0) begin
                  acc_lo_in = req_left_operand & req_mask;
                  state_in  = S_LOOP;
               end else begin
                  state_in  = S_FINISH;
               end
            end
         end
         S_LOOP: begin
            if (kind_ff == KIND_MUL) begin
               // Shift the 128-bit product right, taking in the new partial sum.
               acc_hi_in = add_sum[64:1];
               acc_lo_in = {add_sum[0], acc_lo_ff[63:1]};
            end else if (!add_sum[65]) begin
               // Trial subtract fits: keep it and shift in a one.
               acc_hi_in = add_sum[63:0];
               acc_lo_in = {acc_lo_ff[62:0], 1'b1};
            end else begin
               acc_hi_in = {acc_hi_ff[62:0], acc_lo_ff[63]};
               acc_lo_in = {acc_lo_ff[62:0], 1'b0};
            end
            if (cnt_ff == ITER_LAST) begin
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_FINISH: begin
            // Hold here until the output register is free.
            if (load_rsp) begin
               flags_in = res_flags;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output register: load on finish, drop valid once taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_flags_in  = rsp_flags_ff;
      rsp_cond_in   = rsp_cond_ff;
      rsp_err_in    = rsp_err_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = res_value;
         rsp_flags_in  = res_flags;
         rsp_cond_in   = res_cond;
         rsp_err_in    = res_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      wc_ff         <= wc_in;
      cc_ff         <= cc_in;
      op_a_ff       <= op_a_in;
      op_b_ff       <= op_b_in;
      acc_hi_ff     <= acc_hi_in;
      acc_lo_ff     <= acc_lo_in;
      cnt_ff        <= cnt_in;
      rsp_result_ff <= rsp_result_in;
      rsp_flags_ff  <= rsp_flags_in;
      rsp_cond_ff   <= rsp_cond_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = rsp_result_ff;
   assign rsp_zero_flag      = rsp_flags_ff[FLAG_Z];
   assign rsp_sign_flag      = rsp_flags_ff[FLAG_S];
   assign rsp_carry_flag     = rsp_flags_ff[FLAG_C];
   assign rsp_overflow_flag  = rsp_flags_ff[FLAG_V];
   assign rsp_condition_true = rsp_cond_ff;
   assign rsp_error_code     = rsp_err_ff;

   `ALU_ASSERT_NEXT(a_err_keeps_flags, load_rsp && res_err != ERR_NONE, flags_ff == $past(flags_ff), "error changed the flags")
   `ALU_ASSERT_NEXT(a_loop_exit, state_ff == S_LOOP && cnt_ff == ITER_LAST, state_ff == S_FINISH, "loop overran its step count")
   `ALU_ASSERT_IMP(a_err_zero_result, rsp_valid && rsp_error_code != ERR_NONE, rsp_result_value == '0, "error with nonzero result")
   `ALU_ASSERT_IMP(a_cond_clean, rsp_valid && rsp_condition_true, rsp_error_code == ERR_NONE && rsp_result_value == '0, "condition result not clean")

endmodule
